[hdl/miq_pkg.sv]
// ----------------------------------------------------------------------------
// miq_pkg: shared types and codes for the middle insert queue.
// Holds operation and status codes, the controller state type and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package miq_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_PUSH = 2'd0;
  localparam kind_t KIND_POP  = 2'd1;
  localparam kind_t KIND_MID  = 2'd2;
  localparam kind_t KIND_RSVD = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAL,
    S_MOVE,
    S_EXEC,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item
    logic move_rd;   // read the head of the back ring
    logic move_wr;   // append that entry to the front ring
    logic exec;      // carry out the operation itself
    logic out_load;  // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic kind_valid;  // the captured kind is a real operation
    logic need_move;   // the front ring is shorter than the back ring
  } sts_t;

endpackage

`default_nettype wire

[hdl/middle_insert_queue.sv]
// ----------------------------------------------------------------------------
// middle_insert_queue: FIFO of signed 32-bit values with middle insertion.
// Each item is loaded, then for a used kind code rebalanced if need be and
// executed, and its result is loaded into the output register; an unused
// kind code goes straight to the result. A new item is taken only once the
// previous one ends. Synchronous active-low reset empties both rings at once.
// ----------------------------------------------------------------------------
`default_nettype none

module middle_insert_queue #(
  parameter int CAPACITY = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_kind,
  input  wire logic signed [31:0]  in_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_popped_value
);

  // The queue is kept as a front ring (older half) and a back ring (newer
  // half). Before each operation the controller checks whether the front
  // ring is shorter than the back ring; if so, the head of the back ring is
  // read into a register and then appended to the front ring. This keeps
  // the head of the back ring at the middle of the queue, so a middle insert
  // is just a write in front of that head.
  //
  // The item is then executed: a pop reads the front head, a push writes the
  // back tail, a middle insert writes one entry before the back head. A pop
  // on an empty queue reports empty, and a push or insert with the queue at
  // capacity reports full and drops its value. The result goes into an
  // output register, which lets the next item be taken while the previous
  // result still waits for its transfer.

  miq_pkg::cmd_t cmd;
  miq_pkg::sts_t sts;

  miq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  miq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_popped_value (out_popped_value)
  );

  // At most one datapath command is issued in any cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.move_rd, cmd.move_wr, cmd.exec, cmd.out_load}))
    else $error("more than one datapath command at once");

  // The front ring append always comes in the cycle after a back ring read.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_wr |-> $past(cmd.move_rd))
    else $error("rebalance write without preceding read");

  // After an input transfer the block stalls until the item is finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in progress");

  // A new result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

endmodule

`default_nettype wire

[hdl/miq_datapath.sv]
// ----------------------------------------------------------------------------
// miq_datapath: ring memories, pointers and result registers.
// Both rings have one write and one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module miq_datapath #(
  parameter int CAPACITY = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire miq_pkg::kind_t       in_kind,
  input  wire logic signed [31:0]   in_value,
  input  wire miq_pkg::cmd_t        cmd,
  output miq_pkg::sts_t             sts,
  output miq_pkg::status_t          out_status,
  output logic signed [31:0]        out_popped_value
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= CAP_S) begin
      s = s - CAP_S;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] h);
    return (h == LAST_IDX) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] h);
    return (h == '0) ? LAST_IDX : h - 1'b1;
  endfunction

  logic [31:0] f_mem [CAPACITY];
  logic [31:0] b_mem [CAPACITY];

  miq_pkg::kind_t   kind_r;
  logic [31:0]      value_r;
  miq_pkg::status_t status_r;
  logic             pop_flag_r;
  logic [31:0]      f_rd_r;
  logic [31:0]      b_rd_r;
  miq_pkg::status_t out_status_r;
  logic [31:0]      out_popped_r;

  logic [AW-1:0] f_head_r, f_head_nxt;
  logic [CW-1:0] f_cnt_r, f_cnt_nxt;
  logic [AW-1:0] b_head_r, b_head_nxt;
  logic [CW-1:0] b_cnt_r, b_cnt_nxt;

  logic [AW-1:0] f_tail, b_tail, b_head_dec;
  logic          is_pop, is_push, pop_ok, full, ins_ok;
  logic [SW-1:0] total;

  assign f_tail     = wrap_add(f_head_r, f_cnt_r);
  assign b_tail     = wrap_add(b_head_r, b_cnt_r);
  assign b_head_dec = idx_dec(b_head_r);
  assign total      = SW'(f_cnt_r) + SW'(b_cnt_r);
  assign full       = (total >= CAP_S);
  assign is_pop     = (kind_r == miq_pkg::KIND_POP);
  assign is_push    = (kind_r == miq_pkg::KIND_PUSH);
  assign pop_ok     = is_pop && (f_cnt_r != '0);
  assign ins_ok     = !is_pop && !full;

  assign sts.kind_valid = (kind_r != miq_pkg::KIND_RSVD);
  assign sts.need_move  = (f_cnt_r < b_cnt_r) && (SW'(f_cnt_r) < CAP_S);

  always_comb begin
    f_head_nxt = f_head_r;
    f_cnt_nxt  = f_cnt_r;
    b_head_nxt = b_head_r;
    b_cnt_nxt  = b_cnt_r;
    if (cmd.move_wr) begin
      b_head_nxt = idx_inc(b_head_r);
      b_cnt_nxt  = b_cnt_r - 1'b1;
      f_cnt_nxt  = f_cnt_r + 1'b1;
    end else if (cmd.exec) begin
      if (pop_ok) begin
        f_head_nxt = idx_inc(f_head_r);
        f_cnt_nxt  = f_cnt_r - 1'b1;
      end else if (ins_ok) begin
        b_cnt_nxt = b_cnt_r + 1'b1;
        if (!is_push) begin
          b_head_nxt = b_head_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_head_r <= '0;
      f_cnt_r  <= '0;
      b_head_r <= '0;
      b_cnt_r  <= '0;
    end else begin
      f_head_r <= f_head_nxt;
      f_cnt_r  <= f_cnt_nxt;
      b_head_r <= b_head_nxt;
      b_cnt_r  <= b_cnt_nxt;
    end
  end

  // Front ring: written by the rebalancing move, read by a pop.
  always_ff @(posedge clk) begin
    if (cmd.move_wr) begin
      f_mem[f_tail] <= b_rd_r;
    end
    if (cmd.exec && pop_ok) begin
      f_rd_r <= f_mem[f_head_r];
    end
  end

  // Back ring: read by the rebalancing move, written by push and middle insert.
  always_ff @(posedge clk) begin
    if (cmd.move_rd) begin
      b_rd_r <= b_mem[b_head_r];
    end
    if (cmd.exec && ins_ok) begin
      b_mem[is_push ? b_tail : b_head_dec] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= in_kind;
      value_r    <= in_value;
      status_r   <= miq_pkg::ST_OK;
      pop_flag_r <= 1'b0;
    end else if (cmd.exec) begin
      pop_flag_r <= pop_ok;
      if (is_pop && !pop_ok) begin
        status_r <= miq_pkg::ST_EMPTY;
      end else if (!is_pop && full) begin
        status_r <= miq_pkg::ST_FULL;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_popped_r <= pop_flag_r ? f_rd_r : 32'd0;
    end
  end

  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;

endmodule

`default_nettype wire

[hdl/miq_ctrl.sv]
// ----------------------------------------------------------------------------
// miq_ctrl: operation sequencer and output valid register.
// Steps each item through rebalance and execute as needed, then result load.
// ----------------------------------------------------------------------------
`default_nettype none

module miq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire miq_pkg::sts_t  sts,
  output miq_pkg::cmd_t       cmd
);

  miq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      miq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = miq_pkg::S_BAL;
        end
      end
      miq_pkg::S_BAL: begin
        priority if (!sts.kind_valid) begin
          state_nxt = miq_pkg::S_FINISH;
        end else if (sts.need_move) begin
          state_nxt = miq_pkg::S_MOVE;
        end else begin
          state_nxt = miq_pkg::S_EXEC;
        end
      end
      miq_pkg::S_MOVE:   state_nxt = miq_pkg::S_EXEC;
      miq_pkg::S_EXEC:   state_nxt = miq_pkg::S_FINISH;
      miq_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = miq_pkg::S_IDLE;
        end
      end
      default: state_nxt = miq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      miq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      miq_pkg::S_BAL:    cmd.move_rd  = sts.kind_valid && sts.need_move;
      miq_pkg::S_MOVE:   cmd.move_wr  = 1'b1;
      miq_pkg::S_EXEC:   cmd.exec     = 1'b1;
      miq_pkg::S_FINISH: cmd.out_load = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= miq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
